// ===== rtl/jsu_pkg.sv =====
// jsu_pkg: types and constants for the JSON string unescape decoder.
// No dependencies; imported by json_string_unescape.
package jsu_pkg;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    localparam int MAX_RES    = 4;
    localparam int RES_CW     = $clog2(MAX_RES + 1);

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_BODY    = 4'd1,
        PH_ESC     = 4'd2,
        PH_HEX     = 4'd3,
        PH_PAIR_BS = 4'd4,
        PH_PAIR_U  = 4'd5,
        PH_LOW_HEX = 4'd6,
        PH_UTF8    = 4'd7
    } phase_t;

    typedef enum logic [1:0] {
        K_BYTE = 2'd0,
        K_DONE = 2'd1,
        K_ERR  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_CONTROL   = 4'd1,
        ERR_ESCAPE    = 4'd2,
        ERR_HEX       = 4'd3,
        ERR_SURROGATE = 4'd4,
        ERR_LEAD      = 4'd5,
        ERR_CONT      = 4'd6,
        ERR_RANGE     = 4'd7,
        ERR_TRUNC     = 4'd8
    } err_t;

    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      kind;
        err_t       err;
        logic       last;
    } res_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [20:0] CP_HI_FIRST  = 21'h00D800;
    localparam logic [20:0] CP_HI_LAST   = 21'h00DBFF;
    localparam logic [20:0] CP_LO_FIRST  = 21'h00DC00;
    localparam logic [20:0] CP_LO_LAST   = 21'h00DFFF;
    localparam logic [20:0] CP_PLANE1    = 21'h010000;
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;

    // hex digit value in [3:0], valid flag in [4]
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39)
            r = {1'b1, 4'(b - 8'h30)};
        else if (b >= 8'h61 && b <= 8'h66)
            r = {1'b1, 4'(b - 8'h57)};
        else if (b >= 8'h41 && b <= 8'h46)
            r = {1'b1, 4'(b - 8'h37)};
        return r;
    endfunction

endpackage

// ===== rtl/json_string_unescape.sv =====
// json_string_unescape: JSON string body decoder with strict UTF-8 checking.
// Depends on jsu_pkg for phase, result and error types.
//
// Usage:
// Input channel (in_valid/in_stall) carries one byte of a quoted string body
// per transaction; first_byte marks the byte after the opening quote and
// restarts the decoder, stream_end marks end of document with no byte.
// Output channel (out_valid/out_stall) carries one result per transaction:
// a decoded UTF-8 byte, a done marker for the closing quote, or one error
// with its cause; last flags the final result of an input transaction.
// Each input byte is decoded in the cycle it is accepted and its results
// (zero to four) are written to an 8-entry result queue, from which they
// leave in order, one per cycle while out_stall is low. One input byte is
// accepted per cycle while in_stall is low; in_stall rises only while more
// than four results are queued, which happens when the output side stalls.
// Results hold steady while out_stall is high. Reset empties the queue and
// leaves the decoder idle until a byte with first_byte arrives.
module json_string_unescape
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       first_byte,
    input  logic       stream_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [1:0] kind,
    output logic [3:0] error_code,
    output logic       last
);

    phase_t       phase_reg, phase_next;
    logic [20:0]  code_accum_reg, code_accum_next;
    logic [2:0]   bytes_left_reg, bytes_left_next;
    logic [2:0]   seq_len_reg, seq_len_next;
    logic [9:0]   high_half_reg, high_half_next;

    res_t                 fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0]   cnt_reg, cnt_next;

    logic         fire, pop;

    phase_t       ph;
    logic [20:0]  acc;
    logic [2:0]   bl;
    logic [2:0]   sl;
    logic [9:0]   hh;

    logic [4:0]   hx;
    logic [20:0]  acc_hex, acc_utf, cp_pair;
    logic         ev_fault, ev_done, ev_lit, ev_enc;
    err_t         ev_err;
    logic [7:0]   lit_byte;
    logic [20:0]  enc_cp;

    res_t              res [MAX_RES];
    logic [RES_CW-1:0] res_n;

    assign fire     = in_valid && !in_stall;
    assign in_stall = cnt_reg > FIFO_CW'(FIFO_DEPTH - MAX_RES);
    assign out_valid = cnt_reg != '0;
    assign pop      = out_valid && !out_stall;

    // effective state: first_byte restarts the string
    always_comb
    begin
        if (first_byte)
        begin
            ph  = PH_BODY;
            acc = '0;
            bl  = '0;
            sl  = '0;
            hh  = '0;
        end
        else
        begin
            ph  = phase_reg;
            acc = code_accum_reg;
            bl  = bytes_left_reg;
            sl  = seq_len_reg;
            hh  = high_half_reg;
        end
    end

    assign hx      = hex_val(in_byte);
    assign acc_hex = {acc[16:0], hx[3:0]};
    assign acc_utf = {acc[14:0], in_byte[5:0]};
    assign cp_pair = CP_PLANE1 + {1'b0, hh, acc_hex[9:0]};

    // event decode
    always_comb
    begin
        ev_fault = 1'b0;
        ev_err   = ERR_NONE;
        ev_done  = 1'b0;
        ev_lit   = 1'b0;
        lit_byte = in_byte;
        ev_enc   = 1'b0;
        enc_cp   = acc_hex;
        if (stream_end)
        begin
            if (ph >= PH_BODY && ph <= PH_UTF8)
            begin
                ev_fault = 1'b1;
                ev_err   = ERR_TRUNC;
            end
        end
        else
        begin
            unique case (ph)
                PH_BODY:
                begin
                    if (in_byte == CH_QUOTE)
                        ev_done = 1'b1;
                    else if (in_byte < CH_SPACE)
                    begin
                        ev_fault = 1'b1;
                        ev_err   = ERR_CONTROL;
                    end
                    else if (in_byte == CH_BSLASH)
                        ev_lit = 1'b0;
                    else if (!in_byte[7])
                        ev_lit = 1'b1;
                    else if (in_byte[7:5] != 3'b110 && in_byte[7:4] != 4'b1110
                             && in_byte[7:3] != 5'b11110)
                    begin
                        ev_fault = 1'b1;
                        ev_err   = ERR_LEAD;
                    end
                end
                PH_ESC:
                begin
                    unique case (in_byte)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: ev_lit = 1'b1;
                        CH_B: begin ev_lit = 1'b1; lit_byte = 8'h08; end
                        CH_F: begin ev_lit = 1'b1; lit_byte = 8'h0C; end
                        CH_N: begin ev_lit = 1'b1; lit_byte = 8'h0A; end
                        CH_R: begin ev_lit = 1'b1; lit_byte = 8'h0D; end
                        CH_T: begin ev_lit = 1'b1; lit_byte = 8'h09; end
                        CH_U: ev_lit = 1'b0;
                        default:
                        begin
                            ev_fault = 1'b1;
                            ev_err   = ERR_ESCAPE;
                        end
                    endcase
                end
                PH_HEX, PH_LOW_HEX:
                begin
                    if (!hx[4])
                    begin
                        ev_fault = 1'b1;
                        ev_err   = ERR_HEX;
                    end
                    else if (bl <= 3'd1)
                    begin
                        if (ph == PH_HEX)
                        begin
                            if (acc_hex >= CP_LO_FIRST && acc_hex <= CP_LO_LAST)
                            begin
                                ev_fault = 1'b1;
                                ev_err   = ERR_SURROGATE;
                            end
                            else if (!(acc_hex >= CP_HI_FIRST && acc_hex <= CP_HI_LAST))
                                ev_enc = 1'b1;
                        end
                        else if (acc_hex < CP_LO_FIRST || acc_hex > CP_LO_LAST)
                        begin
                            ev_fault = 1'b1;
                            ev_err   = ERR_SURROGATE;
                        end
                        else
                        begin
                            ev_enc = 1'b1;
                            enc_cp = cp_pair;
                        end
                    end
                end
                PH_PAIR_BS:
                begin
                    if (in_byte != CH_BSLASH)
                    begin
                        ev_fault = 1'b1;
                        ev_err   = ERR_SURROGATE;
                    end
                end
                PH_PAIR_U:
                begin
                    if (in_byte != CH_U)
                    begin
                        ev_fault = 1'b1;
                        ev_err   = ERR_SURROGATE;
                    end
                end
                PH_UTF8:
                begin
                    enc_cp = acc_utf;
                    if (in_byte[7:6] != 2'b10)
                    begin
                        ev_fault = 1'b1;
                        ev_err   = ERR_CONT;
                    end
                    else if (bl <= 3'd1)
                    begin
                        if ((sl == 3'd2 && acc_utf < 21'h80) ||
                            (sl == 3'd3 && acc_utf < 21'h800) ||
                            (sl == 3'd4 && acc_utf < CP_PLANE1) ||
                            (acc_utf >= CP_HI_FIRST && acc_utf <= CP_LO_LAST) ||
                            acc_utf > CP_MAX)
                        begin
                            ev_fault = 1'b1;
                            ev_err   = ERR_RANGE;
                        end
                        else
                            ev_enc = 1'b1;
                    end
                end
                default:
                begin
                    ev_fault = 1'b0;
                end
            endcase
        end
    end

    // next state
    always_comb
    begin
        phase_next      = ph;
        code_accum_next = acc;
        bytes_left_next = bl;
        seq_len_next    = sl;
        high_half_next  = hh;
        if (!stream_end)
        begin
            unique case (ph)
                PH_BODY:
                begin
                    if (in_byte == CH_BSLASH)
                        phase_next = PH_ESC;
                    else if (in_byte[7:5] == 3'b110)
                    begin
                        seq_len_next    = 3'd2;
                        code_accum_next = {16'd0, in_byte[4:0]};
                        bytes_left_next = 3'd1;
                        phase_next      = PH_UTF8;
                    end
                    else if (in_byte[7:4] == 4'b1110)
                    begin
                        seq_len_next    = 3'd3;
                        code_accum_next = {17'd0, in_byte[3:0]};
                        bytes_left_next = 3'd2;
                        phase_next      = PH_UTF8;
                    end
                    else if (in_byte[7:3] == 5'b11110)
                    begin
                        seq_len_next    = 3'd4;
                        code_accum_next = {18'd0, in_byte[2:0]};
                        bytes_left_next = 3'd3;
                        phase_next      = PH_UTF8;
                    end
                end
                PH_ESC:
                begin
                    if (in_byte == CH_U)
                    begin
                        code_accum_next = '0;
                        bytes_left_next = 3'd4;
                        phase_next      = PH_HEX;
                    end
                    else
                        phase_next = PH_BODY;
                end
                PH_HEX, PH_LOW_HEX:
                begin
                    code_accum_next = acc_hex;
                    if (bl > 3'd1)
                        bytes_left_next = bl - 3'd1;
                    else
                    begin
                        bytes_left_next = '0;
                        if (ph == PH_HEX && acc_hex >= CP_HI_FIRST && acc_hex <= CP_HI_LAST)
                        begin
                            high_half_next = acc_hex[9:0];
                            phase_next     = PH_PAIR_BS;
                        end
                        else
                            phase_next = PH_BODY;
                    end
                end
                PH_PAIR_BS:
                    phase_next = PH_PAIR_U;
                PH_PAIR_U:
                begin
                    code_accum_next = '0;
                    bytes_left_next = 3'd4;
                    phase_next      = PH_LOW_HEX;
                end
                PH_UTF8:
                begin
                    code_accum_next = acc_utf;
                    if (bl > 3'd1)
                        bytes_left_next = bl - 3'd1;
                    else
                    begin
                        bytes_left_next = '0;
                        phase_next      = PH_BODY;
                    end
                end
                default:
                    phase_next = ph;
            endcase
        end
        if (ev_fault || ev_done)
            phase_next = PH_IDLE;
    end

    // result entries for this transaction
    always_comb
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            res[i] = '{out_byte: 8'h00, kind: K_BYTE, err: ERR_NONE, last: 1'b0};
        end
        res_n = '0;
        if (ev_fault)
        begin
            res[0] = '{out_byte: 8'h00, kind: K_ERR, err: ev_err, last: 1'b1};
            res_n  = RES_CW'(1);
        end
        else if (ev_done)
        begin
            res[0] = '{out_byte: 8'h00, kind: K_DONE, err: ERR_NONE, last: 1'b1};
            res_n  = RES_CW'(1);
        end
        else if (ev_lit)
        begin
            res[0].out_byte = lit_byte;
            res[0].last     = 1'b1;
            res_n           = RES_CW'(1);
        end
        else if (ev_enc)
        begin
            if (enc_cp < 21'h80)
            begin
                res[0].out_byte = {1'b0, enc_cp[6:0]};
                res[0].last     = 1'b1;
                res_n           = RES_CW'(1);
            end
            else if (enc_cp < 21'h800)
            begin
                res[0].out_byte = {3'b110, enc_cp[10:6]};
                res[1].out_byte = {2'b10, enc_cp[5:0]};
                res[1].last     = 1'b1;
                res_n           = RES_CW'(2);
            end
            else if (enc_cp < CP_PLANE1)
            begin
                res[0].out_byte = {4'b1110, enc_cp[15:12]};
                res[1].out_byte = {2'b10, enc_cp[11:6]};
                res[2].out_byte = {2'b10, enc_cp[5:0]};
                res[2].last     = 1'b1;
                res_n           = RES_CW'(3);
            end
            else
            begin
                res[0].out_byte = {5'b11110, enc_cp[20:18]};
                res[1].out_byte = {2'b10, enc_cp[17:12]};
                res[2].out_byte = {2'b10, enc_cp[11:6]};
                res[3].out_byte = {2'b10, enc_cp[5:0]};
                res[3].last     = 1'b1;
                res_n           = RES_CW'(4);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            code_accum_reg <= '0;
            bytes_left_reg <= '0;
            seq_len_reg    <= '0;
            high_half_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            code_accum_reg <= code_accum_next;
            bytes_left_reg <= bytes_left_next;
            seq_len_reg    <= seq_len_next;
            high_half_reg  <= high_half_next;
        end
    end

    // result queue
    always_comb
    begin
        cnt_next = cnt_reg;
        if (fire)
            cnt_next = cnt_next + FIFO_CW'(res_n);
        if (pop)
            cnt_next = cnt_next - FIFO_CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (fire)
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(res_n);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (fire && RES_CW'(i) < res_n)
                fifo_mem[wr_ptr_reg + FIFO_AW'(i)] <= res[i];
        end
    end

    assign out_byte   = fifo_mem[rd_ptr_reg].out_byte;
    assign kind       = fifo_mem[rd_ptr_reg].kind;
    assign error_code = fifo_mem[rd_ptr_reg].err;
    assign last       = fifo_mem[rd_ptr_reg].last;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !first_byte && phase_reg == PH_IDLE) |-> res_n == '0)
        else $error("idle decoder produced a result");

    a_ctrl_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != K_BYTE) |-> (out_byte == 8'h00 && last))
        else $error("done or error result not a single zero byte");

    a_trunc_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && first_byte && stream_end) |=> phase_reg == PH_IDLE)
        else $error("decoder not idle after truncated start");

endmodule

// ===== tb/json_string_unescape_chk.sv =====
// json_string_unescape_chk: watches both channels of json_string_unescape, predicts the
// decoded bytes, done and error results for every input transaction and compares them.
// Depends on jsu_pkg for result, phase, kind and error types and character constants.
module json_string_unescape_chk
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       first_byte,
    input  logic       stream_end,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] out_byte,
    input  logic [1:0] kind,
    input  logic [3:0] error_code,
    input  logic       last,
    output int         fail_count,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    phase_t      ph;
    logic [20:0] acc;
    logic [2:0]  left;
    logic [2:0]  seq_len;
    logic [9:0]  hi_half;

    res_t        step_res [MAX_RES];
    int          n_res;
    res_t        decoded_q [$];
    res_t        want;

    function automatic void clear_state();
        ph      = PH_IDLE;
        acc     = '0;
        left    = '0;
        seq_len = '0;
        hi_half = '0;
    endfunction

    function automatic void emit(input logic [7:0] b, input kind_t k, input err_t e);
        step_res[n_res].out_byte = b;
        step_res[n_res].kind     = k;
        step_res[n_res].err      = e;
        step_res[n_res].last     = 1'b0;
        n_res++;
    endfunction

    function automatic void abort(input err_t e);
        ph = PH_IDLE;
        emit(8'h00, K_ERR, e);
    endfunction

    function automatic void emit_code(input logic [20:0] cp);
        if (cp < 21'h80)
        begin
            emit(cp[7:0], K_BYTE, ERR_NONE);
        end
        else if (cp < 21'h800)
        begin
            emit({3'b110, cp[10:6]}, K_BYTE, ERR_NONE);
            emit({2'b10, cp[5:0]}, K_BYTE, ERR_NONE);
        end
        else if (cp < CP_PLANE1)
        begin
            emit({4'b1110, cp[15:12]}, K_BYTE, ERR_NONE);
            emit({2'b10, cp[11:6]}, K_BYTE, ERR_NONE);
            emit({2'b10, cp[5:0]}, K_BYTE, ERR_NONE);
        end
        else
        begin
            emit({5'b11110, cp[20:18]}, K_BYTE, ERR_NONE);
            emit({2'b10, cp[17:12]}, K_BYTE, ERR_NONE);
            emit({2'b10, cp[11:6]}, K_BYTE, ERR_NONE);
            emit({2'b10, cp[5:0]}, K_BYTE, ERR_NONE);
        end
    endfunction

    function automatic void decode_input(input logic [7:0] b, input logic f, input logic e);
        int          nib;
        logic [20:0] cp;
        n_res = 0;
        if (f)
        begin
            clear_state();
            ph = PH_BODY;
        end
        if (e)
        begin
            if (ph != PH_IDLE)
                abort(ERR_TRUNC);
        end
        else
        begin
            case (ph)
                PH_BODY:
                begin
                    if (b == CH_QUOTE)
                    begin
                        ph = PH_IDLE;
                        emit(8'h00, K_DONE, ERR_NONE);
                    end
                    else if (b < CH_SPACE)
                        abort(ERR_CONTROL);
                    else if (b == CH_BSLASH)
                        ph = PH_ESC;
                    else if (b < 8'h80)
                        emit(b, K_BYTE, ERR_NONE);
                    else if (b[7:5] == 3'b110)
                    begin
                        seq_len = 3'd2;
                        acc     = {16'd0, b[4:0]};
                    end
                    else if (b[7:4] == 4'b1110)
                    begin
                        seq_len = 3'd3;
                        acc     = {17'd0, b[3:0]};
                    end
                    else if (b[7:3] == 5'b11110)
                    begin
                        seq_len = 3'd4;
                        acc     = {18'd0, b[2:0]};
                    end
                    else
                        abort(ERR_LEAD);
                    if (ph == PH_BODY && b >= 8'h80 && b[7:3] != 5'b11111 && b[7:6] == 2'b11)
                    begin
                        left = seq_len - 3'd1;
                        ph   = PH_UTF8;
                    end
                end
                PH_ESC:
                begin
                    ph = PH_BODY;
                    case (b)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: emit(b, K_BYTE, ERR_NONE);
                        CH_B: emit(8'h08, K_BYTE, ERR_NONE);
                        CH_F: emit(8'h0C, K_BYTE, ERR_NONE);
                        CH_N: emit(8'h0A, K_BYTE, ERR_NONE);
                        CH_R: emit(8'h0D, K_BYTE, ERR_NONE);
                        CH_T: emit(8'h09, K_BYTE, ERR_NONE);
                        CH_U:
                        begin
                            acc  = '0;
                            left = 3'd4;
                            ph   = PH_HEX;
                        end
                        default: abort(ERR_ESCAPE);
                    endcase
                end
                PH_HEX, PH_LOW_HEX:
                begin
                    if (b >= 8'h30 && b <= 8'h39)
                        nib = b - 8'h30;
                    else if (b >= 8'h61 && b <= 8'h66)
                        nib = b - 8'h57;
                    else if (b >= 8'h41 && b <= 8'h46)
                        nib = b - 8'h37;
                    else
                        nib = -1;
                    if (nib < 0)
                        abort(ERR_HEX);
                    else
                    begin
                        acc = {acc[16:0], 4'(nib)};
                        if (left > 3'd1)
                            left--;
                        else
                        begin
                            left = '0;
                            cp   = acc;
                            if (ph == PH_HEX)
                            begin
                                if (cp >= CP_HI_FIRST && cp <= CP_HI_LAST)
                                begin
                                    hi_half = 10'(cp - CP_HI_FIRST);
                                    ph      = PH_PAIR_BS;
                                end
                                else if (cp >= CP_LO_FIRST && cp <= CP_LO_LAST)
                                    abort(ERR_SURROGATE);
                                else
                                begin
                                    ph = PH_BODY;
                                    emit_code(cp);
                                end
                            end
                            else if (cp < CP_LO_FIRST || cp > CP_LO_LAST)
                                abort(ERR_SURROGATE);
                            else
                            begin
                                ph = PH_BODY;
                                emit_code(CP_PLANE1 + {hi_half, 10'd0} + (cp - CP_LO_FIRST));
                            end
                        end
                    end
                end
                PH_PAIR_BS:
                begin
                    if (b != CH_BSLASH)
                        abort(ERR_SURROGATE);
                    else
                        ph = PH_PAIR_U;
                end
                PH_PAIR_U:
                begin
                    if (b != CH_U)
                        abort(ERR_SURROGATE);
                    else
                    begin
                        acc  = '0;
                        left = 3'd4;
                        ph   = PH_LOW_HEX;
                    end
                end
                PH_UTF8:
                begin
                    if (b[7:6] != 2'b10)
                        abort(ERR_CONT);
                    else
                    begin
                        acc = {acc[14:0], b[5:0]};
                        if (left > 3'd1)
                            left--;
                        else
                        begin
                            left = '0;
                            cp   = acc;
                            if ((seq_len == 3'd2 && cp < 21'h80) ||
                                (seq_len == 3'd3 && cp < 21'h800) ||
                                (seq_len == 3'd4 && cp < CP_PLANE1) ||
                                (cp >= CP_HI_FIRST && cp <= CP_LO_LAST) || cp > CP_MAX)
                                abort(ERR_RANGE);
                            else
                            begin
                                ph = PH_BODY;
                                emit_code(cp);
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        if (n_res > 0)
            step_res[n_res - 1].last = 1'b1;
        for (int i = 0; i < n_res; i++)
            decoded_q.push_back(step_res[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_state();
            decoded_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (decoded_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result: byte %h kind %0d code %0d last %b",
                                 $realtime, out_byte, kind, error_code, last);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (out_byte !== want.out_byte || kind !== want.kind ||
                        error_code !== want.err || last !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $write("%0t: result differs: expected byte %h kind %0d code %0d last %b",
                                   $realtime, want.out_byte, want.kind, want.err, want.last);
                            $display(", got byte %h kind %0d code %0d last %b",
                                     out_byte, kind, error_code, last);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
                decode_input(in_byte, first_byte, stream_end);
        end
        pending = decoded_q.size();
    end

endmodule

// ===== tb/json_string_unescape_tb.sv =====
// json_string_unescape_tb: drives JSON string bodies (well-formed and faulty) into
// json_string_unescape with random idling on both sides; json_string_unescape_chk judges.
// Depends on jsu_pkg, json_string_unescape and json_string_unescape_chk.
module json_string_unescape_tb
    import jsu_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic [7:0] in_byte    = 8'h00;
    logic       first_byte = 1'b0;
    logic       stream_end = 1'b0;
    logic       out_stall  = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [3:0] error_code;
    logic       last;

    int         fail_count;
    int         pending;
    int         src_pct    = 0;
    int         snk_pct    = 0;
    int         sent_items = 0;
    int         target;
    logic [7:0] body_q [$];

    json_string_unescape u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .first_byte (first_byte),
        .stream_end (stream_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .kind       (kind),
        .error_code (error_code),
        .last       (last)
    );

    json_string_unescape_chk u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .first_byte (first_byte),
        .stream_end (stream_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .kind       (kind),
        .error_code (error_code),
        .last       (last),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < snk_pct);

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic push_item(input logic [7:0] b, input logic f, input logic e);
        while ($urandom_range(99) < src_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        in_byte    <= b;
        first_byte <= f;
        stream_end <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] base;
        if (n < 4'd10)
            return 8'h30 + n;
        base = $urandom_range(1) ? 8'h41 : 8'h61;
        return base + n - 8'd10;
    endfunction

    function automatic void push_u_escape(input logic [15:0] v);
        body_q.push_back(CH_BSLASH);
        body_q.push_back(CH_U);
        for (int i = 3; i >= 0; i--)
            body_q.push_back(hex_char(v[i * 4 +: 4]));
    endfunction

    // raw UTF-8 of cp forced to len bytes (len 2..4), overlong when cp is small
    function automatic void push_raw(input logic [20:0] cp, input int len);
        if (len == 2)
            body_q.push_back({3'b110, cp[10:6]});
        else if (len == 3)
            body_q.push_back({4'b1110, cp[15:12]});
        else
            body_q.push_back({5'b11110, cp[20:18]});
        if (len == 4)
            body_q.push_back({2'b10, cp[17:12]});
        if (len >= 3)
            body_q.push_back({2'b10, cp[11:6]});
        body_q.push_back({2'b10, cp[5:0]});
    endfunction

    // appends one token to body_q; returns 1 when the token is a fault
    function automatic bit add_token();
        int          r;
        int          len;
        logic [7:0]  b;
        logic [15:0] v;
        logic [20:0] cp;
        r = $urandom_range(99);
        if (r < 30)
        begin
            b = 8'($urandom_range(8'h7F, 8'h20));
            if (b == CH_QUOTE || b == CH_BSLASH)
                b = 8'h61;
            body_q.push_back(b);
        end
        else if (r < 42)
        begin
            case ($urandom_range(7))
                0: b = CH_QUOTE;
                1: b = CH_BSLASH;
                2: b = CH_SLASH;
                3: b = CH_B;
                4: b = CH_F;
                5: b = CH_N;
                6: b = CH_R;
                default: b = CH_T;
            endcase
            body_q.push_back(CH_BSLASH);
            body_q.push_back(b);
        end
        else if (r < 54)
        begin
            v = ($urandom_range(3) == 0) ? 16'($urandom_range(8'h7F)) : 16'($urandom);
            if (v >= CP_HI_FIRST[15:0] && v <= CP_LO_LAST[15:0])
                v ^= 16'h4000;
            push_u_escape(v);
        end
        else if (r < 64)
        begin
            push_u_escape(CP_HI_FIRST[15:0] | 16'($urandom_range(10'h3FF)));
            push_u_escape(CP_LO_FIRST[15:0] | 16'($urandom_range(10'h3FF)));
        end
        else if (r < 88)
        begin
            len = $urandom_range(4, 2);
            if (len == 2)
                cp = 21'($urandom_range(11'h7FF, 8'h80));
            else if (len == 3)
            begin
                cp = 21'($urandom_range(16'hFFFF, 12'h800));
                if (cp >= CP_HI_FIRST && cp <= CP_LO_LAST)
                    cp ^= 21'h4000;
            end
            else
                cp = 21'($urandom_range(CP_MAX, CP_PLANE1));
            push_raw(cp, len);
        end
        else
        begin
            case ($urandom_range(11))
                0: body_q.push_back(8'($urandom_range(8'h1F)));
                1:
                begin
                    b = 8'($urandom);
                    case (b)
                        CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U:
                            b = 8'h78;
                        default: ;
                    endcase
                    body_q.push_back(CH_BSLASH);
                    body_q.push_back(b);
                end
                2:
                begin
                    body_q.push_back(CH_BSLASH);
                    body_q.push_back(CH_U);
                    repeat ($urandom_range(3))
                        body_q.push_back(hex_char(4'($urandom)));
                    b = 8'($urandom);
                    if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
                        (b >= 8'h61 && b <= 8'h66))
                        b = 8'h67;
                    body_q.push_back(b);
                end
                3: push_u_escape(CP_LO_FIRST[15:0] | 16'($urandom_range(10'h3FF)));
                4:
                begin
                    push_u_escape(CP_HI_FIRST[15:0] | 16'($urandom_range(10'h3FF)));
                    b = 8'($urandom);
                    if (b == CH_BSLASH)
                        b = 8'h41;
                    body_q.push_back(b);
                end
                5:
                begin
                    push_u_escape(CP_HI_FIRST[15:0] | 16'($urandom_range(10'h3FF)));
                    body_q.push_back(CH_BSLASH);
                    b = 8'($urandom);
                    if (b == CH_U)
                        b = CH_N;
                    body_q.push_back(b);
                end
                6:
                begin
                    push_u_escape(CP_HI_FIRST[15:0] | 16'($urandom_range(10'h3FF)));
                    v = 16'($urandom);
                    if (v >= CP_LO_FIRST[15:0] && v <= CP_LO_LAST[15:0])
                        v ^= 16'h2000;
                    push_u_escape(v);
                end
                7: body_q.push_back($urandom_range(1) ? 8'($urandom_range(8'hBF, 8'h80))
                                                      : 8'($urandom_range(8'hFF, 8'hF8)));
                8:
                begin
                    b   = 8'($urandom_range(8'hF4, 8'hC2));
                    len = (b >= 8'hF0) ? 4 : (b >= 8'hE0) ? 3 : 2;
                    body_q.push_back(b);
                    repeat ($urandom_range(len - 2))
                        body_q.push_back(8'h80 | 8'($urandom_range(8'h3F)));
                    b = 8'($urandom);
                    if (b[7:6] == 2'b10)
                        b[6] = 1'b1;
                    body_q.push_back(b);
                end
                9:
                begin
                    len = $urandom_range(4, 2);
                    push_raw(21'($urandom_range(len == 2 ? 32'h7F : len == 3 ? 32'h7FF
                                                                             : 32'hFFFF)), len);
                end
                10: push_raw(CP_HI_FIRST + 21'($urandom_range(11'h7FF)), 3);
                default: push_raw(21'($urandom_range(21'h1FFFFF, 21'h110000)), 4);
            endcase
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic send_string();
        int n_tok;
        int r;
        bit faulted;
        body_q.delete();
        faulted = 1'b0;
        if ($urandom_range(19) == 0)
        begin
            push_item(8'($urandom), 1'b1, 1'b1);
            sent_items++;
            return;
        end
        n_tok = $urandom_range(8, 1);
        for (int i = 0; i < n_tok && !faulted; i++)
            faulted = add_token();
        foreach (body_q[i])
            push_item(body_q[i], i == 0, 1'b0);
        sent_items += body_q.size();
        r = $urandom_range(99);
        if (!faulted && r < 80)
        begin
            push_item(CH_QUOTE, 1'b0, 1'b0);
            sent_items++;
        end
        else if (!faulted && r < 90)
        begin
            push_item(8'($urandom), 1'b0, 1'b1);
            sent_items++;
        end
        // trailing junk: ignored after a close or fault, decoded if left open
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(3, 1))
                push_item(8'($urandom), 1'b0, 1'($urandom_range(1)));
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n   <= 1'b1;
        src_pct = 33;
        snk_pct = 62;

        // idle: no result
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b1);
        // restart and end of document together
        push_item(8'h00, 1'b1, 1'b1);
        // top ASCII, escaped slash, U+10FFFF raw, close
        push_item(8'h7F, 1'b1, 1'b0);
        push_item(CH_BSLASH, 1'b0, 1'b0);
        push_item(CH_SLASH, 1'b0, 1'b0);
        push_item(8'hF4, 1'b0, 1'b0);
        push_item(8'h8F, 1'b0, 1'b0);
        push_item(8'hBF, 1'b0, 1'b0);
        push_item(8'hBF, 1'b0, 1'b0);
        push_item(CH_QUOTE, 1'b0, 1'b0);
        // lone low surrogate escape
        push_item(CH_BSLASH, 1'b1, 1'b0);
        push_item(CH_U, 1'b0, 1'b0);
        push_item(8'h44, 1'b0, 1'b0);
        push_item(8'h63, 1'b0, 1'b0);
        push_item(8'h30, 1'b0, 1'b0);
        push_item(8'h30, 1'b0, 1'b0);
        // overlong NUL
        push_item(8'hC0, 1'b1, 1'b0);
        push_item(8'h80, 1'b0, 1'b0);
        // bad lead, raw control
        push_item(8'hFF, 1'b1, 1'b0);
        push_item(8'h1F, 1'b1, 1'b0);
        // document ends inside a string
        push_item(8'h41, 1'b1, 1'b0);
        push_item(8'h00, 1'b0, 1'b1);

        for (int p = 0; p < 3; p++)
        begin
            src_pct = (p == 0) ? 33 : (p == 1) ? 62 : 0;
            snk_pct = (p == 0) ? 62 : (p == 1) ? 33 : 0;
            target  = sent_items + 33;
            while (sent_items < target)
                send_string();
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("json_string_unescape: match");
        else
            $display("json_string_unescape: mismatch");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("json_string_unescape: mismatch");
        $finish;
    end

endmodule
